[hw/rtl/lps_pkg.sv]
package lps_pkg;

  localparam int unsigned PosW  = 7;
  localparam int unsigned SelW  = 3;
  localparam int unsigned TickW = 6;
  localparam int unsigned ByteW = 8;
  localparam int unsigned StepW = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  localparam logic [StepW-1:0] DelayStepRst = 4'd6;
  localparam logic [StepW-1:0] DelayMinRst  = 4'd3;
  localparam logic [TickW-1:0] DelayWrapRst = 6'd39;

  localparam logic [CfgIdxW-1:0] CfgDelayStep = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDelayMin  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDelayWrap = 2'd2;

  localparam logic OpTick  = 1'b0;
  localparam logic OpWrite = 1'b1;

  typedef struct packed {
    logic [SelW-1:0]  pattern_sel;
    logic             reverse_on;
    logic [TickW-1:0] frame_ticks;
  } lps_meta_t;

  typedef struct packed {
    logic            issue;
    logic [PosW-1:0] position;
    lps_meta_t       meta;
  } lps_frame_req_t;

  function automatic logic [PosW-1:0] pat_start(input logic [SelW-1:0] sel);
    logic [PosW-1:0] s;
    unique case (sel)
      3'd0:    s = 7'd0;
      3'd1:    s = 7'd32;
      3'd2:    s = 7'd48;
      3'd3:    s = 7'd56;
      3'd4:    s = 7'd88;
      default: s = 7'd0;
    endcase
    return s;
  endfunction

  function automatic logic [PosW-1:0] pat_size(input logic [SelW-1:0] sel);
    logic [PosW-1:0] n;
    unique case (sel)
      3'd0:    n = 7'd32;
      3'd1:    n = 7'd16;
      3'd2:    n = 7'd8;
      3'd3:    n = 7'd32;
      3'd4:    n = 7'd32;
      default: n = 7'd32;
    endcase
    return n;
  endfunction

endpackage

[hw/rtl/lps_if.sv]
interface lps_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic                      delay_button;
  logic                      pattern_button;
  logic [lps_pkg::PosW-1:0]  table_address;
  logic [lps_pkg::ByteW-1:0] table_data;

  modport source (
    output valid, operation, delay_button, pattern_button, table_address, table_data,
    input  ready
  );
  modport sink (
    input  valid, operation, delay_button, pattern_button, table_address, table_data,
    output ready
  );
endinterface

interface lps_out_if;
  logic                      valid;
  logic                      ready;
  logic [15:0]               led_word;
  logic [lps_pkg::SelW-1:0]  pattern_number;
  logic                      reverse_on;
  logic [lps_pkg::TickW-1:0] frame_ticks;

  modport source (
    output valid, led_word, pattern_number, reverse_on, frame_ticks,
    input  ready
  );
  modport sink (
    input  valid, led_word, pattern_number, reverse_on, frame_ticks,
    output ready
  );
endinterface

[hw/rtl/lps_ram.sv]
module lps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/lps_ctrl.sv]
module lps_ctrl #(
  parameter int unsigned PATTERN_COUNT = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            delay_button_i,
  input  logic                            pattern_button_i,
  input  logic                            cfg_we_i,
  input  logic [lps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lps_pkg::CfgDataW-1:0]    cfg_data_i,
  output lps_pkg::lps_frame_req_t         req_o
);

  import lps_pkg::*;

  localparam logic [SelW:0] PatCount = (SelW+1)'(PATTERN_COUNT);

  logic [StepW-1:0] delay_step_q, delay_min_q;
  logic [TickW-1:0] delay_wrap_q;

  logic [SelW-1:0]  sel_q, sel_d;
  logic             rev_q, rev_d;
  logic             back_q, back_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [TickW-1:0] tick_left_q, tick_left_d;
  logic [TickW-1:0] delay_q, delay_d;
  logic             dheld_q, pheld_q;
  logic             restart_q, restart_d;

  logic [TickW:0]   d_sum;
  logic [SelW:0]    sel_inc;
  logic             boundary;
  logic [PosW-1:0]  start, size;
  logic [PosW:0]    pend, pos2;
  logic [PosW-1:0]  adv_pos;
  logic             adv_back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_step_q <= DelayStepRst;
      delay_min_q  <= DelayMinRst;
      delay_wrap_q <= DelayWrapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDelayStep: delay_step_q <= cfg_data_i[StepW-1:0];
        CfgDelayMin:  delay_min_q  <= cfg_data_i[StepW-1:0];
        CfgDelayWrap: delay_wrap_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    d_sum   = {1'b0, delay_q} + {3'b000, delay_step_q};
    delay_d = delay_q;
    if (delay_button_i && !dheld_q) begin
      delay_d = (d_sum >= {1'b0, delay_wrap_q}) ? {2'b00, delay_min_q} : d_sum[TickW-1:0];
    end

    sel_inc   = {1'b0, sel_q} + 4'd1;
    sel_d     = sel_q;
    rev_d     = rev_q;
    restart_d = restart_q;
    if (pattern_button_i && !pheld_q) begin
      restart_d = 1'b1;
      if (!rev_q) begin
        rev_d = 1'b1;
      end else begin
        rev_d = 1'b0;
        sel_d = (sel_inc >= PatCount) ? '0 : sel_inc[SelW-1:0];
      end
    end

    start = pat_start(sel_d);
    size  = pat_size(sel_d);
    pend  = {1'b0, start} + {1'b0, size};
    pos2  = {1'b0, pos_q} + 8'd2;

    adv_back = back_q;
    adv_pos  = start;
    if (!back_q) begin
      if (pos2 < pend) begin
        adv_pos = pos2[PosW-1:0];
      end else if (rev_d && size >= 7'd6) begin
        adv_back = 1'b1;
        adv_pos  = 7'(pend - 8'd4);
      end
    end else begin
      if ({1'b0, pos_q} >= {1'b0, start} + 8'd4) begin
        adv_pos = pos_q - 7'd2;
      end else begin
        adv_back = 1'b0;
      end
    end

    boundary    = (tick_left_q == '0) || (tick_left_q == 6'd1);
    tick_left_d = (tick_left_q == '0) ? '0 : tick_left_q - 6'd1;
    back_d      = back_q;
    pos_d       = pos_q;
    if (boundary) begin
      tick_left_d = delay_d;
      if (restart_d) begin
        restart_d = 1'b0;
        back_d    = 1'b0;
        pos_d     = start;
      end else begin
        back_d = adv_back;
        pos_d  = adv_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      rev_q       <= 1'b0;
      back_q      <= 1'b0;
      pos_q       <= '0;
      tick_left_q <= '0;
      delay_q     <= {2'b00, DelayMinRst};
      dheld_q     <= 1'b0;
      pheld_q     <= 1'b0;
      restart_q   <= 1'b1;
    end else if (tick_i) begin
      sel_q       <= sel_d;
      rev_q       <= rev_d;
      back_q      <= back_d;
      pos_q       <= pos_d;
      tick_left_q <= tick_left_d;
      delay_q     <= delay_d;
      dheld_q     <= delay_button_i;
      pheld_q     <= pattern_button_i;
      restart_q   <= restart_d;
    end
  end

  assign req_o.issue            = tick_i && boundary;
  assign req_o.position         = pos_d;
  assign req_o.meta.pattern_sel = sel_d;
  assign req_o.meta.reverse_on  = rev_d;
  assign req_o.meta.frame_ticks = delay_d;

endmodule

[hw/rtl/led_pattern_sequencer.sv]
// A tick that starts a frame reads the pattern store, one RAM copy per byte of the frame; the
// read data is registered in the store, then in the output register, where it waits on a stall.
// Throughput: one item per cycle, ticks and store writes alike, except while a stalled result backs up the read.
// Reset clears all control and playback state and loads the register defaults at once;
// the pattern store is not cleared and holds garbage until written.
module led_pattern_sequencer #(
  parameter int unsigned STORE_DEPTH   = 128,
  parameter int unsigned PATTERN_COUNT = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  lps_in_if.sink                       in_if,
  lps_out_if.source                    out_if,
  input  logic                         cfg_we_i,
  input  logic [lps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lps_pkg::CfgDataW-1:0] cfg_data_i
);

  import lps_pkg::*;

  localparam int unsigned AddrW = $clog2(STORE_DEPTH);

  function automatic logic [AddrW-1:0] wrap_addr(input logic [PosW:0] a);
    logic [PosW+1:0] v;
    v = {1'b0, a};
    for (int i = 0; i < 8; i++) begin
      if (v >= (PosW+2)'(STORE_DEPTH)) begin
        v = v - (PosW+2)'(STORE_DEPTH);
      end
    end
    return v[AddrW-1:0];
  endfunction

  lps_frame_req_t   req;
  logic             in_ready, in_accept, tick, wr;
  logic             s1_valid_q, s1_move;
  lps_meta_t        s1_meta_q;
  logic             out_valid_q;
  logic [15:0]      out_word_q;
  lps_meta_t        out_meta_q;
  logic [ByteW-1:0] rd_hi, rd_lo;
  logic [AddrW-1:0] waddr, raddr_hi, raddr_lo;

  assign s1_move   = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_ready  = !s1_valid_q || s1_move;
  assign in_accept = in_if.valid && in_ready;
  assign tick      = in_accept && (in_if.operation == OpTick);
  assign wr        = in_accept && (in_if.operation == OpWrite);

  lps_ctrl #(
    .PATTERN_COUNT(PATTERN_COUNT)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .tick_i           (tick),
    .delay_button_i   (in_if.delay_button),
    .pattern_button_i (in_if.pattern_button),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .req_o            (req)
  );

  assign waddr    = wrap_addr({1'b0, in_if.table_address});
  assign raddr_hi = wrap_addr({1'b0, req.position});
  assign raddr_lo = wrap_addr({1'b0, req.position} + 8'd1);

  lps_ram #(.Width(ByteW), .Depth(STORE_DEPTH)) u_ram_hi (
    .clk_i,
    .we_i    (wr),
    .waddr_i (waddr),
    .wdata_i (in_if.table_data),
    .re_i    (req.issue),
    .raddr_i (raddr_hi),
    .rdata_o (rd_hi)
  );

  lps_ram #(.Width(ByteW), .Depth(STORE_DEPTH)) u_ram_lo (
    .clk_i,
    .we_i    (wr),
    .waddr_i (waddr),
    .wdata_i (in_if.table_data),
    .re_i    (req.issue),
    .raddr_i (raddr_lo),
    .rdata_o (rd_lo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req.issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.issue) begin
      s1_meta_q <= req.meta;
    end
    if (s1_move) begin
      out_word_q <= {rd_hi, rd_lo};
      out_meta_q <= s1_meta_q;
    end
  end

  assign in_if.ready           = in_ready;
  assign out_if.valid          = out_valid_q;
  assign out_if.led_word       = out_word_q;
  assign out_if.pattern_number = out_meta_q.pattern_sel;
  assign out_if.reverse_on     = out_meta_q.reverse_on;
  assign out_if.frame_ticks    = out_meta_q.frame_ticks;

endmodule

[hw/rtl/lps_checker.sv]
module lps_checker #(
  parameter int unsigned PATTERN_COUNT = 5
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_led_word,
  input logic [2:0]  out_pattern_number,
  input logic        out_reverse_on,
  input logic [5:0]  out_frame_ticks
);

  import lps_pkg::*;

  localparam logic [SelW:0] PatCount = (SelW+1)'(PATTERN_COUNT);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_led_word)
      && $stable(out_pattern_number) && $stable(out_reverse_on) && $stable(out_frame_ticks))
    else $error("result changed while stalled");

  a_frame_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_operation == OpTick), 2))
    else $error("result without a tick transfer two cycles earlier");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

  a_pattern_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ({1'b0, out_pattern_number} < PatCount))
    else $error("pattern number out of range");

endmodule

bind led_pattern_sequencer lps_checker #(
  .PATTERN_COUNT(PATTERN_COUNT)
) u_lps_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_operation       (in_if.operation),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_led_word       (out_if.led_word),
  .out_pattern_number (out_if.pattern_number),
  .out_reverse_on     (out_if.reverse_on),
  .out_frame_ticks    (out_if.frame_ticks)
);
